### rtl/rsed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsed_pkg
// Shared types and constants for the RTC stable-read epoch decoder.
// ----------------------------------------------------------------------------
package rsed_pkg;

    localparam int SNAP_W = 56;
    localparam logic [3:0] RETRY_RESET = 4'd5;

    // Accumulator start value: -(719499 + 15) modulo 2^32. The 15 is the
    // constant y/100 - y/400 over March-based years 1999..2099.
    localparam logic [31:0] DAY_OFFSET = 32'd4294247782;

    localparam logic [16:0] MUL_YEAR_DAYS = 17'd365;
    localparam logic [16:0] MUL_DAY_SECS  = 17'd86400;
    localparam logic [16:0] MUL_HOUR_SECS = 17'd3600;
    localparam logic [16:0] MUL_MIN_SECS  = 17'd60;
    localparam logic [16:0] MUL_ONE       = 17'd1;

    localparam logic [1:0] BASE_ACC    = 2'd0;
    localparam logic [1:0] BASE_OFFSET = 2'd1;
    localparam logic [1:0] BASE_ZERO   = 2'd2;

    typedef struct packed {
        logic       start_req;
        logic [7:0] seconds_reg;
        logic [7:0] minutes_reg;
        logic [7:0] hours_reg;
        logic [7:0] weekday_reg;
        logic [7:0] date_reg;
        logic [7:0] month_reg;
        logic [7:0] year_reg;
    } t_in;

    typedef struct packed {
        logic        valid_res;
        logic        exhausted;
        logic        stop_flag;
        logic        osc_fail_flag;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic [2:0]  weekday_out;
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [11:0] year_out;
        logic [31:0] epoch_seconds;
    } t_out;

    // Decoded snapshot; digits are weighted as is, so values may exceed range
    typedef struct packed {
        logic [6:0]  sec;
        logic [6:0]  min;
        logic [5:0]  hour;
        logic [2:0]  wday;
        logic [5:0]  day;
        logic [4:0]  mon;
        logic [11:0] year;
        logic [11:0] cal_y;
        logic [3:0]  cal_m;
        logic        ok;
    } t_dec;

    typedef struct packed {
        logic        en;
        logic [1:0]  base_sel;
        logic        a_acc;
        logic [16:0] op_a;
        logic [16:0] op_b;
    } t_mac_ctl;

    // floor(367 * m / 12) for March-based month m
    function automatic logic [8:0] month_day_offset(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd30;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd91;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd152;
            4'd6:    d = 9'd183;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd244;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd305;
            4'd11:   d = 9'd336;
            4'd12:   d = 9'd367;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### rtl/rtc_stable_read_epoch_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_stable_read_epoch_decoder
// Compares successive RTC register snapshots and decodes an agreed time to
// calendar fields and Unix epoch seconds.
// ----------------------------------------------------------------------------
//  Channel  Direction  Signals                        Notes
//  in       input      i_in_valid/o_in_ready/i_in     one snapshot per transfer
//  out      output     o_out_valid/i_out_ready/o_out  one result per snapshot
//  cfg      input      i_cfg_we/i_cfg_wdata           max_retries, write only
//
//  A snapshot passes IDLE, EVAL and DONE, and CALC for a valid time: the epoch
//  is built in 8 steps of the one shared multiply-accumulate unit.
//  The result sits in an output register; the next snapshot is taken while
//  it waits, and the block stalls at its end until that register is free.
//  Synchronous active-low reset clears the acquisition state; max_retries = 5.
// ----------------------------------------------------------------------------
module rtc_stable_read_epoch_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rsed_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output rsed_pkg::t_out  o_out,
    input  logic            i_cfg_we,
    input  logic [3:0]      i_cfg_wdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_CALC = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [2:0] STEP_YEAR  = 3'd0;
    localparam logic [2:0] STEP_LEAP  = 3'd1;
    localparam logic [2:0] STEP_MONTH = 3'd2;
    localparam logic [2:0] STEP_DAY   = 3'd3;
    localparam logic [2:0] STEP_SCALE = 3'd4;
    localparam logic [2:0] STEP_HOUR  = 3'd5;
    localparam logic [2:0] STEP_MIN   = 3'd6;
    localparam logic [2:0] STEP_SEC   = 3'd7;

    logic [1:0]                     r_state, n_state;
    logic [2:0]                     r_step, n_step;
    logic [3:0]                     r_max_retries;
    logic [3:0]                     r_attempt, n_attempt;
    logic                           r_acquiring, n_acquiring;
    logic [rsed_pkg::SNAP_W-1:0]    r_prev, n_prev;
    rsed_pkg::t_in                  r_in;
    logic                           r_res_valid, n_res_valid;
    logic                           r_res_exh, n_res_exh;
    logic                           r_out_valid, n_out_valid;
    rsed_pkg::t_out                 r_out, n_out;

    rsed_pkg::t_dec                 w_dec;
    rsed_pkg::t_mac_ctl             w_ctl;
    logic [31:0]                    w_acc;
    logic [rsed_pkg::SNAP_W-1:0]    w_snap;
    logic [3:0]                     w_limit;
    logic                           w_out_free;

    rsed_decode u_decode (
        .i_snap (r_in),
        .o_dec  (w_dec)
    );

    rsed_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .o_acc (w_acc)
    );

    assign w_snap     = r_in[rsed_pkg::SNAP_W-1:0];
    assign w_limit    = (r_max_retries == 4'd0) ? 4'd1 : r_max_retries;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Step sequence of the shared unit
    always_comb begin
        w_ctl.en       = (r_state == ST_CALC);
        w_ctl.base_sel = rsed_pkg::BASE_ACC;
        w_ctl.a_acc    = 1'b0;
        w_ctl.op_a     = 17'd0;
        w_ctl.op_b     = rsed_pkg::MUL_ONE;
        case (r_step)
            STEP_YEAR: begin
                w_ctl.base_sel = rsed_pkg::BASE_OFFSET;
                w_ctl.op_a     = 17'(w_dec.cal_y);
                w_ctl.op_b     = rsed_pkg::MUL_YEAR_DAYS;
            end
            STEP_LEAP:  w_ctl.op_a = 17'(w_dec.cal_y[11:2]);
            STEP_MONTH: w_ctl.op_a = 17'(rsed_pkg::month_day_offset(w_dec.cal_m));
            STEP_DAY:   w_ctl.op_a = 17'(w_dec.day);
            STEP_SCALE: begin
                w_ctl.base_sel = rsed_pkg::BASE_ZERO;
                w_ctl.a_acc    = 1'b1;
                w_ctl.op_b     = rsed_pkg::MUL_DAY_SECS;
            end
            STEP_HOUR: begin
                w_ctl.op_a = 17'(w_dec.hour);
                w_ctl.op_b = rsed_pkg::MUL_HOUR_SECS;
            end
            STEP_MIN: begin
                w_ctl.op_a = 17'(w_dec.min);
                w_ctl.op_b = rsed_pkg::MUL_MIN_SECS;
            end
            STEP_SEC:   w_ctl.op_a = 17'(w_dec.sec);
            default:    w_ctl.op_a = 17'd0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_attempt   = r_attempt;
        n_acquiring = r_acquiring;
        n_prev      = r_prev;
        n_res_valid = r_res_valid;
        n_res_exh   = r_res_exh;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_res_valid = 1'b0;
                n_res_exh   = 1'b0;
                n_state     = ST_DONE;
                if (r_in.start_req) begin
                    n_prev      = w_snap;
                    n_attempt   = 4'd0;
                    n_acquiring = 1'b1;
                end else if (r_acquiring) begin
                    n_prev    = w_snap;
                    n_attempt = r_attempt + 4'd1;
                    if ((r_prev == w_snap) && w_dec.ok) begin
                        n_acquiring = 1'b0;
                        n_res_valid = 1'b1;
                        n_step      = STEP_YEAR;
                        n_state     = ST_CALC;
                    end else if (n_attempt >= w_limit) begin
                        n_acquiring = 1'b0;
                        n_res_exh   = 1'b1;
                    end
                end
            end
            ST_CALC: begin
                n_step = r_step + 3'd1;
                if (r_step == STEP_SEC) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid             = 1'b1;
                    n_out                   = '0;
                    n_out.valid_res         = r_res_valid;
                    n_out.exhausted         = r_res_exh;
                    n_out.stop_flag         = r_in.seconds_reg[7];
                    n_out.osc_fail_flag     = r_in.minutes_reg[7];
                    if (r_res_valid) begin
                        n_out.hour_out      = w_dec.hour[4:0];
                        n_out.minute_out    = w_dec.min[5:0];
                        n_out.second_out    = w_dec.sec[5:0];
                        n_out.weekday_out   = w_dec.wday;
                        n_out.day_out       = w_dec.day[4:0];
                        n_out.month_out     = w_dec.mon[3:0];
                        n_out.year_out      = w_dec.year;
                        n_out.epoch_seconds = w_acc;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_step        <= STEP_YEAR;
            r_max_retries <= rsed_pkg::RETRY_RESET;
            r_attempt     <= 4'd0;
            r_acquiring   <= 1'b0;
            r_prev        <= '0;
            r_res_valid   <= 1'b0;
            r_res_exh     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_attempt   <= n_attempt;
            r_acquiring <= n_acquiring;
            r_prev      <= n_prev;
            r_res_valid <= n_res_valid;
            r_res_exh   <= n_res_exh;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_retries <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
        r_out <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/rsed_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsed_decode
// BCD decode and range check of one snapshot, plus March-based calendar terms.
// ----------------------------------------------------------------------------
module rsed_decode (
    input  rsed_pkg::t_in  i_snap,
    output rsed_pkg::t_dec o_dec
);

    always_comb begin
        rsed_pkg::t_dec d;
        d.sec  = 7'(i_snap.seconds_reg[3:0]) + 7'(i_snap.seconds_reg[6:4]) * 7'd10;
        d.min  = 7'(i_snap.minutes_reg[3:0]) + 7'(i_snap.minutes_reg[6:4]) * 7'd10;
        d.hour = 6'(i_snap.hours_reg[3:0]) + 6'(i_snap.hours_reg[5:4]) * 6'd10;
        d.wday = i_snap.weekday_reg[2:0];
        d.day  = 6'(i_snap.date_reg[3:0]) + 6'(i_snap.date_reg[5:4]) * 6'd10;
        d.mon  = 5'(i_snap.month_reg[3:0]) + 5'(i_snap.month_reg[4]) * 5'd10;
        d.year = 12'd2000 + 12'(i_snap.year_reg[3:0]) + 12'(i_snap.year_reg[7:4]) * 12'd10;
        d.ok   = (d.sec < 7'd60) && (d.min < 7'd60) && (d.hour < 6'd24) &&
                 (d.wday != 3'd0) && (d.day != 6'd0) && (d.day <= 6'd31) &&
                 (d.mon != 5'd0) && (d.mon <= 5'd12) && (d.year < 12'd2100);
        // January and February belong to the previous March-based year
        if (d.mon <= 5'd2) begin
            d.cal_m = 4'(d.mon + 5'd10);
            d.cal_y = d.year - 12'd1;
        end else begin
            d.cal_m = 4'(d.mon - 5'd2);
            d.cal_y = d.year;
        end
        o_dec = d;
    end

endmodule

### rtl/rsed_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsed_mac
// Shared multiply-accumulate unit: acc <= base + a * b, 17x17 multiplier.
// ----------------------------------------------------------------------------
module rsed_mac (
    input  logic               i_clk,
    input  rsed_pkg::t_mac_ctl i_ctl,
    output logic [31:0]        o_acc
);

    logic [31:0] r_acc;
    logic [31:0] n_acc;
    logic [16:0] w_a;
    logic [33:0] w_prod;
    logic [31:0] w_base;

    always_comb begin
        w_a    = i_ctl.a_acc ? {1'b0, r_acc[15:0]} : i_ctl.op_a;
        w_prod = w_a * i_ctl.op_b;
        case (i_ctl.base_sel)
            rsed_pkg::BASE_ACC:    w_base = r_acc;
            rsed_pkg::BASE_OFFSET: w_base = rsed_pkg::DAY_OFFSET;
            rsed_pkg::BASE_ZERO:   w_base = 32'd0;
            default:               w_base = 32'd0;
        endcase
        n_acc = i_ctl.en ? (w_base + w_prod[31:0]) : r_acc;
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RTC stable-read epoch decoder. Snapshots go in
// over a bursty valid/ready sender and results come out to a receiver with its
// own stall pattern. Every accepted snapshot is run through a local model of
// the acquisition and the time/epoch decode, and each result is checked field
// by field in order. max_retries is swept across phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 255;
    localparam int N_PHASES    = 6;

    logic           i_clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           o_in_ready;
    rsed_pkg::t_in  in_item = '0;
    logic           o_out_valid;
    logic           out_ready = 1'b0;
    rsed_pkg::t_out o_out;
    logic           cfg_we = 1'b0;
    logic [3:0]     cfg_wdata = '0;

    rtc_stable_read_epoch_decoder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Local copy of the acquisition state
    logic [55:0] last_snap = '0;
    logic [3:0]  tries = '0;
    bit          acquiring = 1'b0;
    logic [3:0]  retry_limit = rsed_pkg::RETRY_RESET;

    rsed_pkg::t_in  pending_snaps [$];
    rsed_pkg::t_out expected_times [$];
    int   issued_cnt = 0;
    int   result_cnt = 0;
    int   err_cnt = 0;

    function automatic logic [31:0] civil_epoch(longint unsigned yr, longint unsigned mo,
                                                longint unsigned dy, longint unsigned hh,
                                                longint unsigned mm, longint unsigned ss);
        longint unsigned m;
        longint unsigned y;
        longint unsigned days;
        m = mo;
        y = yr;
        // March-based year: January and February close the previous year
        if (m <= 2) begin
            m = m + 10;
            y = y - 1;
        end else begin
            m = m - 2;
        end
        days = y / 4 - y / 100 + y / 400 + (367 * m) / 12 + dy + y * 365 - 719499;
        return 32'(days * 86400 + hh * 3600 + mm * 60 + ss);
    endfunction

    task automatic decode_snapshot(input rsed_pkg::t_in it, output rsed_pkg::t_out r);
        logic [55:0] snap;
        int unsigned sec, mnt, hr, wd, dy, mo, yr, lim;
        bit          same, ok;
        snap = it[55:0];
        r = '0;
        r.stop_flag = it.seconds_reg[7];
        r.osc_fail_flag = it.minutes_reg[7];
        if (it.start_req) begin
            last_snap = snap;
            tries = '0;
            acquiring = 1'b1;
        end else if (acquiring) begin
            same = (last_snap == snap);
            sec = int'(it.seconds_reg[3:0]) + 10 * int'(it.seconds_reg[6:4]);
            mnt = int'(it.minutes_reg[3:0]) + 10 * int'(it.minutes_reg[6:4]);
            hr  = int'(it.hours_reg[3:0]) + 10 * int'(it.hours_reg[5:4]);
            wd  = int'(it.weekday_reg[2:0]);
            dy  = int'(it.date_reg[3:0]) + 10 * int'(it.date_reg[5:4]);
            mo  = int'(it.month_reg[3:0]) + 10 * int'(it.month_reg[4]);
            yr  = int'(it.year_reg[3:0]) + 10 * int'(it.year_reg[7:4]);
            ok = sec < 60 && mnt < 60 && hr < 24 && wd >= 1 && dy >= 1 && dy <= 31 &&
                 mo >= 1 && mo <= 12 && yr < 100;
            lim = (retry_limit == 0) ? 1 : int'(retry_limit);
            last_snap = snap;
            tries = tries + 4'd1;
            if (same && ok) begin
                acquiring = 1'b0;
                r.valid_res = 1'b1;
                r.hour_out = 5'(hr);
                r.minute_out = 6'(mnt);
                r.second_out = 6'(sec);
                r.weekday_out = 3'(wd);
                r.day_out = 5'(dy);
                r.month_out = 4'(mo);
                r.year_out = 12'(2000 + yr);
                r.epoch_seconds = civil_epoch(2000 + yr, mo, dy, hr, mnt, sec);
            end else if (int'(tries) >= lim) begin
                acquiring = 1'b0;
                r.exhausted = 1'b1;
            end
        end
    endtask

    task automatic push_snap(input bit st, input logic [55:0] snap);
        pending_snaps.push_back(rsed_pkg::t_in'({st, snap}));
        issued_cnt++;
    endtask

    function automatic logic [7:0] bcd(int v);
        return 8'(((v / 10) << 4) | (v % 10));
    endfunction

    function automatic logic [55:0] rand_raw();
        return 56'({$urandom(), $urandom()});
    endfunction

    // In-range time with random flag and don't-care bits
    function automatic logic [55:0] rand_good();
        logic [7:0] s, mi, h, w, d, mo, y;
        s  = bcd($urandom_range(0, 59)) | (8'($urandom_range(0, 1)) << 7);
        mi = bcd($urandom_range(0, 59)) | (8'($urandom_range(0, 1)) << 7);
        h  = bcd($urandom_range(0, 23)) | (8'($urandom_range(0, 3)) << 6);
        w  = 8'($urandom_range(1, 7)) | (8'($urandom_range(0, 31)) << 3);
        d  = bcd($urandom_range(1, 31)) | (8'($urandom_range(0, 3)) << 6);
        mo = bcd($urandom_range(1, 12)) | (8'($urandom_range(0, 7)) << 5);
        y  = bcd($urandom_range(0, 99));
        return {s, mi, h, w, d, mo, y};
    endfunction

    task automatic gen_acquisition(input logic [3:0] retry_val);
        int          kind, n_follow, lim, i, r;
        logic [55:0] cur;
        kind = $urandom_range(0, 9);
        lim = (retry_val == 0) ? 1 : int'(retry_val);
        if (kind == 0) begin
            push_snap($urandom_range(0, 1), rand_raw());
        end else if (kind == 1) begin
            push_snap(1'b0, rand_raw());
        end else begin
            cur = ($urandom_range(0, 9) == 0) ? rand_raw() : rand_good();
            push_snap(1'b1, cur);
            n_follow = $urandom_range(1, lim + 1);
            for (i = 1; i <= n_follow; i++) begin
                r = $urandom_range(0, 7);
                if (i == n_follow && $urandom_range(0, 1) == 1) begin
                    push_snap(1'b0, cur);
                end else if (r == 0) begin
                    push_snap(1'b1, cur);
                end else begin
                    if (r <= 3) begin
                        cur = cur ^ (56'd1 << $urandom_range(0, 55));
                    end else if (r <= 5) begin
                        cur = rand_good();
                    end else begin
                        cur = rand_raw();
                    end
                    push_snap(1'b0, cur);
                end
            end
        end
    endtask

    task automatic write_retry(input logic [3:0] v);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        retry_limit = v;
    endtask

    task automatic wait_idle();
        wait (result_cnt == issued_cnt);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin : driver
        rsed_pkg::t_out r;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                decode_snapshot(in_item, r);
                expected_times.push_back(r);
            end
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (pending_snaps.size() > 0) begin
                    in_valid <= 1'b1;
                    in_item <= pending_snaps.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall mode is picked at random and changes over time
    int stall_mode = 0;
    int mode_left = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin : receiver
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 400);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 1);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    out_ready <= 1'b0;
                end else begin
                    out_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 60);
                end
            end
        endcase
    end

    always @(posedge i_clk) begin : monitor
        rsed_pkg::t_out want;
        if (rst_n && o_out_valid && out_ready) begin
            if (expected_times.size() == 0) begin
                err_cnt++;
                $display("%0t: result transfer with nothing expected, expected none actual %0h",
                         $time, o_out);
            end else begin
                want = expected_times.pop_front();
                check_field("valid_res", want.valid_res, o_out.valid_res);
                check_field("exhausted", want.exhausted, o_out.exhausted);
                check_field("stop_flag", want.stop_flag, o_out.stop_flag);
                check_field("osc_fail_flag", want.osc_fail_flag, o_out.osc_fail_flag);
                check_field("hour_out", want.hour_out, o_out.hour_out);
                check_field("minute_out", want.minute_out, o_out.minute_out);
                check_field("second_out", want.second_out, o_out.second_out);
                check_field("weekday_out", want.weekday_out, o_out.weekday_out);
                check_field("day_out", want.day_out, o_out.day_out);
                check_field("month_out", want.month_out, o_out.month_out);
                check_field("year_out", want.year_out, o_out.year_out);
                check_field("epoch_seconds", want.epoch_seconds, o_out.epoch_seconds);
            end
            result_cnt++;
        end
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int         phase;
        int         stop_at;
        logic [3:0] retry_val;
        repeat (10) @(posedge i_clk);
        rst_n <= 1'b1;

        // Snapshots while idle yield a result with no time
        push_snap(1'b0, 56'h0);
        push_snap(1'b0, {56{1'b1}});
        // First and last instants of the range
        push_snap(1'b1, 56'h00_00_00_01_01_01_00);
        push_snap(1'b0, 56'h00_00_00_01_01_01_00);
        push_snap(1'b1, 56'hD9_D9_E3_FF_F1_F2_99);
        push_snap(1'b0, 56'hD9_D9_E3_FF_F1_F2_99);
        // February 31 rolls into March
        push_snap(1'b1, 56'h00_30_12_03_31_02_24);
        push_snap(1'b0, 56'h00_30_12_03_31_02_24);
        // Non-decimal nibbles that still land in range
        push_snap(1'b1, 56'h4A_1F_0F_02_1F_0A_3C);
        push_snap(1'b0, 56'h4A_1F_0F_02_1F_0A_3C);
        // Agreement on garbage, then a restart mid-acquisition
        push_snap(1'b1, {56{1'b1}});
        push_snap(1'b0, {56{1'b1}});
        push_snap(1'b1, 56'h56_34_12_06_15_06_24);
        push_snap(1'b0, 56'h57_34_12_06_15_06_24);
        push_snap(1'b0, 56'h58_34_12_06_15_06_24);
        push_snap(1'b0, 56'h59_34_12_06_15_06_24);
        push_snap(1'b0, 56'h00_35_12_06_15_06_24);
        // Match on the last allowed try
        push_snap(1'b0, 56'h00_35_12_06_15_06_24);
        // Differences in flag and unused bits, then an invalid weekday, then run out of tries
        push_snap(1'b1, 56'h00_00_00_01_01_01_00);
        push_snap(1'b0, 56'h80_00_00_01_01_01_00);
        push_snap(1'b0, 56'h80_00_40_01_01_01_00);
        push_snap(1'b0, 56'h80_00_40_09_01_01_00);
        push_snap(1'b0, 56'h80_00_40_08_01_01_00);
        push_snap(1'b0, 56'h80_00_40_08_01_01_00);
        push_snap(1'b0, 56'h12_34_56_07_28_11_42);
        wait_idle();

        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: retry_val = 4'd1;
                1: retry_val = 4'd15;
                2: retry_val = 4'd0;
                default: retry_val = 4'($urandom_range(1, 15));
            endcase
            write_retry(retry_val);
            stop_at = issued_cnt + PHASE_ITEMS;
            while (issued_cnt < stop_at) gen_acquisition(retry_val);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (expected_times.size() != 0) begin
            err_cnt++;
            $display("%0t: results missing, expected %0d more actual 0",
                     $time, expected_times.size());
        end
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
